/* src/gmd_pkg.sv */
// ----------------------------------------------------------------------------
// gmd_pkg
// shared types and constants for the grid maze depth-first walker
// ----------------------------------------------------------------------------
package gmd_pkg;

    localparam int unsigned STACK_DEPTH = 64;
    localparam int unsigned STACK_AW    = 6;
    localparam int unsigned DEPTH_W     = 7;
    localparam int unsigned SIZE_W      = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd5;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 4'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN   = 1'b1;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_INIT,
        S_TRY,
        S_CHECK,
        S_POP,
        S_POPWAIT,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic wr_cell;
        logic clear;
        logic init;
        logic next_dir;
        logic enter;
        logic pop;
        logic load_top;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic nb_ok;
        logic wall;
        logic goal;
        logic dir_last;
        logic depth_one;
        logic clear_last;
    } t_stat;

endpackage

/* src/gmd_ram.sv */
// ----------------------------------------------------------------------------
// gmd_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module gmd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/gmd_ctrl.sv */
// ----------------------------------------------------------------------------
// gmd_ctrl
// sequencer for cell writes and the depth-first walk
// ----------------------------------------------------------------------------
module gmd_ctrl
    import gmd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_cmd,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_cmd == CMD_RUN) n_state = S_CLEAR;
            end
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_INIT;
            end
            S_INIT: n_state = S_TRY;
            S_TRY: begin
                if (i_stat.nb_ok)         n_state = S_CHECK;
                else if (i_stat.dir_last) n_state = S_POP;
            end
            S_CHECK: begin
                if (i_stat.wall) begin
                    n_state = i_stat.dir_last ? S_POP : S_TRY;
                end else begin
                    n_state = i_stat.goal ? S_FLUSH : S_TRY;
                end
            end
            S_POP:     n_state = i_stat.depth_one ? S_FLUSH : S_POPWAIT;
            S_POPWAIT: n_state = S_TRY;
            S_FLUSH:   n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.wr_cell = i_start && i_cmd == CMD_WRITE;
            end
            S_CLEAR:   o_cmd.clear = 1'b1;
            S_INIT:    o_cmd.init = 1'b1;
            S_TRY:     o_cmd.next_dir = !i_stat.nb_ok;
            S_CHECK: begin
                o_cmd.next_dir = i_stat.wall;
                o_cmd.enter    = !i_stat.wall;
            end
            S_POP:     o_cmd.pop = 1'b1;
            S_POPWAIT: o_cmd.load_top = 1'b1;
            S_FLUSH:   o_cmd.flush = 1'b1;
            default:   o_busy = 1'b1;
        endcase
    end

endmodule

/* src/gmd_dpath.sv */
// ----------------------------------------------------------------------------
// gmd_dpath
// wall map, visited map, path stack, neighbour check and result register
// ----------------------------------------------------------------------------
module gmd_dpath
    import gmd_pkg::*;
#(
    parameter int unsigned GRID_SIZE = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic [2:0]        i_row,
    input  logic [2:0]        i_col,
    input  logic              i_wall,
    output t_stat             o_stat,
    output logic              o_valid,
    output logic [2:0]        o_visit_row,
    output logic [2:0]        o_visit_col,
    output logic              o_reached_goal,
    output logic              o_last
);

    localparam int unsigned RW    = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int unsigned AW    = RW + 3;
    localparam int unsigned CELLS = 1 << AW;
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(GRID_SIZE);

    logic [SIZE_W-1:0]   r_size;
    logic [SIZE_W-1:0]   w_n;
    logic [2:0]          r_cur_r;
    logic [2:0]          r_cur_c;
    logic [1:0]          r_dir;
    logic [DEPTH_W-1:0]  r_depth;
    logic [AW-1:0]       r_clr;
    logic [CELLS-1:0]    r_wall_vld;
    logic                r_vld_q;
    logic [2:0]          r_pend_r;
    logic [2:0]          r_pend_c;
    logic                r_pend_goal;

    logic [2:0]          w_nr;
    logic [2:0]          w_nc;
    logic                w_inb;
    logic [AW-1:0]       w_nb_addr;
    logic [AW-1:0]       w_wr_addr;
    logic                w_wr_ok;
    logic                w_wall_q_raw;
    logic                w_wall_q;
    logic                w_vis_we;
    logic [AW-1:0]       w_vis_waddr;
    logic                w_vis_q;
    logic                w_stk_we;
    logic [STACK_AW-1:0] w_stk_waddr;
    logic [5:0]          w_stk_wdata;
    logic [5:0]          w_stk_rdata;
    logic [DEPTH_W-1:0]  w_depth_m2;

    // size in use clamped to the legal range
    always_comb begin
        if (r_size < SIZE_MIN)      w_n = SIZE_MIN;
        else if (r_size > SIZE_MAX) w_n = SIZE_MAX;
        else                        w_n = r_size;
    end

    // neighbour of the current cell in the direction under test
    always_comb begin
        w_nr  = r_cur_r;
        w_nc  = r_cur_c;
        w_inb = 1'b0;
        case (r_dir)
            DIR_RIGHT: begin
                w_nc  = r_cur_c + 3'd1;
                w_inb = ({1'b0, r_cur_c} + 4'd1) < w_n;
            end
            DIR_UP: begin
                w_nr  = r_cur_r - 3'd1;
                w_inb = r_cur_r != 3'd0;
            end
            DIR_LEFT: begin
                w_nc  = r_cur_c - 3'd1;
                w_inb = r_cur_c != 3'd0;
            end
            DIR_DOWN: begin
                w_nr  = r_cur_r + 3'd1;
                w_inb = ({1'b0, r_cur_r} + 4'd1) < w_n;
            end
            default: w_inb = 1'b0;
        endcase
    end

    assign w_nb_addr = {w_nr[RW-1:0], w_nc};
    assign w_wr_addr = {i_row[RW-1:0], i_col};
    // rows past the grid are never reached, so they need no storage
    assign w_wr_ok   = {1'b0, i_row} < SIZE_MAX;
    assign w_wall_q  = r_vld_q & w_wall_q_raw;
    assign w_depth_m2 = r_depth - DEPTH_W'(2);

    // visited map: cleared one cell per cycle, then the start cell is marked
    assign w_vis_we    = i_cmd.clear || i_cmd.init || i_cmd.enter;
    assign w_vis_waddr = i_cmd.clear ? r_clr : (i_cmd.init ? {AW{1'b0}} : w_nb_addr);

    // the start cell sits at the bottom of the path stack
    assign w_stk_we    = i_cmd.init || i_cmd.enter;
    assign w_stk_waddr = i_cmd.init ? {STACK_AW{1'b0}} : r_depth[STACK_AW-1:0];
    assign w_stk_wdata = i_cmd.init ? 6'd0 : {w_nr, w_nc};

    gmd_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_cell && w_wr_ok),
        .i_waddr (w_wr_addr),
        .i_wdata (i_wall),
        .i_raddr (w_nb_addr),
        .o_rdata (w_wall_q_raw)
    );

    gmd_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_visited_ram (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (!i_cmd.clear),
        .i_raddr (w_nb_addr),
        .o_rdata (w_vis_q)
    );

    gmd_ram #(
        .WIDTH (6),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_depth_m2[STACK_AW-1:0]),
        .o_rdata (w_stk_rdata)
    );

    // blocked by a wall or by an earlier visit
    assign o_stat.nb_ok      = w_inb;
    assign o_stat.wall       = w_wall_q || w_vis_q;
    assign o_stat.goal       = ({1'b0, w_nr} == w_n - 4'd1) && ({1'b0, w_nc} == w_n - 4'd1);
    assign o_stat.dir_last   = r_dir == DIR_DOWN;
    assign o_stat.depth_one  = r_depth == DEPTH_W'(1);
    assign o_stat.clear_last = r_clr == {AW{1'b1}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= SIZE_RESET;
            r_depth    <= '0;
            r_dir      <= DIR_RIGHT;
            r_clr      <= '0;
            r_wall_vld <= '0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= i_cmd.enter || i_cmd.flush;
            if (i_cfg_we) r_size <= i_cfg_data;
            if (i_cmd.wr_cell && w_wr_ok) r_wall_vld[w_wr_addr] <= 1'b1;
            if (i_cmd.clear) r_clr <= r_clr + AW'(1);
            if (i_cmd.init) begin
                r_depth <= DEPTH_W'(1);
                r_dir   <= DIR_RIGHT;
            end
            if (i_cmd.next_dir) r_dir <= r_dir + 2'd1;
            if (i_cmd.enter) begin
                r_depth <= r_depth + DEPTH_W'(1);
                r_dir   <= DIR_RIGHT;
            end
            if (i_cmd.pop) r_depth <= r_depth - DEPTH_W'(1);
            if (i_cmd.load_top) r_dir <= DIR_RIGHT;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_vld_q <= r_wall_vld[w_nb_addr];
        if (i_cmd.init) begin
            r_cur_r     <= 3'd0;
            r_cur_c     <= 3'd0;
            r_pend_r    <= 3'd0;
            r_pend_c    <= 3'd0;
            r_pend_goal <= 1'b0;
        end
        if (i_cmd.load_top) begin
            r_cur_r <= w_stk_rdata[5:3];
            r_cur_c <= w_stk_rdata[2:0];
        end
        // the previous cell goes out once the next one is known
        if (i_cmd.enter) begin
            o_visit_row    <= r_pend_r;
            o_visit_col    <= r_pend_c;
            o_reached_goal <= 1'b0;
            o_last         <= 1'b0;
            r_cur_r        <= w_nr;
            r_cur_c        <= w_nc;
            r_pend_r       <= w_nr;
            r_pend_c       <= w_nc;
            r_pend_goal    <= o_stat.goal;
        end
        if (i_cmd.flush) begin
            o_visit_row    <= r_pend_r;
            o_visit_col    <= r_pend_c;
            o_reached_goal <= r_pend_goal;
            o_last         <= 1'b1;
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("path stack depth out of range");

    a_enter_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.enter |-> w_inb && !w_vis_q)
        else $error("walk entered a visited or outside cell");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_depth != '0)
        else $error("pop from an empty path stack");

    a_goal_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reached_goal |-> o_last)
        else $error("goal flag on a word that is not the last");

endmodule

/* src/grid_maze_depth_first_search_top.sv */
// ----------------------------------------------------------------------------
// grid_maze_depth_first_search_top
// depth-first maze walker over a square grid of wall bits
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A cell write leaves
// busy low. A run first clears the visited map, one cell per cycle over the
// whole stored grid, then sets up the walk, then walks from the top-left cell
// toward the far corner and emits one word per cell entered, each on the
// o_visit_* ports for one cycle with o_valid high; the receiver cannot stall,
// so every word must be taken when shown. A neighbour outside the grid is
// skipped without a map read; one inside is checked against the wall and
// visited maps, which are rams with a registered read. A backtrack pops the
// path stack and then waits for its registered read, but the one that empties
// the stack goes straight to the final word. A flush state issues the final
// word, which shows in the same cycle that busy drops. The last word of a run
// carries o_last, and o_reached_goal when the far corner was entered. busy is
// high for the whole run.
// ----------------------------------------------------------------------------
module grid_maze_depth_first_search_top
    import gmd_pkg::*;
#(
    parameter int unsigned GRID_SIZE = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cmd,
    input  logic [2:0]        i_row,
    input  logic [2:0]        i_col,
    input  logic              i_wall,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    output logic              o_valid,
    output logic [2:0]        o_visit_row,
    output logic [2:0]        o_visit_col,
    output logic              o_reached_goal,
    output logic              o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    gmd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    gmd_dpath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_wall         (i_wall),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .o_visit_row    (o_visit_row),
        .o_visit_col    (o_visit_col),
        .o_reached_goal (o_reached_goal),
        .o_last         (o_last)
    );

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("busy still high after the final word");

endmodule

/* test/grid_maze_depth_first_search_top_tb.sv */
// ----------------------------------------------------------------------------
// grid_maze_depth_first_search_top_tb
// self-checking bench for the depth-first grid maze walker
// ----------------------------------------------------------------------------
// A scripted opening loads walls and starts runs at the grid sizes of interest:
// the open grid, a wall on the start cell, a boxed-in start, a sealed goal and
// out-of-range sizes. Random phases follow. Each phase sets a new size, then
// mixes cell writes with runs under different sender idle rates. An in-bench
// walker mirrors the grid and the size register, expands every accepted run
// into its visit words and checks each word on o_valid in order.
// ----------------------------------------------------------------------------
module grid_maze_depth_first_search_top_tb;
    import gmd_pkg::*;

    localparam int GRID_N      = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_WORDS = 20;
    localparam int IDLE_PCT [N_PHASES] = '{0, 86, 0, 21, 86, 21, 0, 86};

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       goal;
        logic       last;
    } visit_t;

    typedef struct packed {
        logic              is_cfg;
        logic [SIZE_W-1:0] size;
        logic              cmd;
        logic [2:0]        row;
        logic [2:0]        col;
        logic              wall;
        logic              typed;
        logic [2:0]        fin_row;
        logic [2:0]        fin_col;
        logic              fin_goal;
    } step_t;

    // final visit word is typed in only where the walk is obvious
    localparam step_t SCRIPT [25] = '{
        '{1'b0, 4'd0, CMD_RUN,   3'd0, 3'd0, 1'b0, 1'b1, 3'd4, 3'd4, 1'b1},
        '{1'b0, 4'd0, CMD_WRITE, 3'd0, 3'd0, 1'b1, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_RUN,   3'd0, 3'd0, 1'b0, 1'b1, 3'd4, 3'd4, 1'b1},
        '{1'b0, 4'd0, CMD_WRITE, 3'd0, 3'd1, 1'b1, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_WRITE, 3'd1, 3'd0, 1'b1, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_RUN,   3'd7, 3'd7, 1'b1, 1'b1, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_WRITE, 3'd7, 3'd7, 1'b1, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_WRITE, 3'd0, 3'd1, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_WRITE, 3'd1, 3'd0, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_WRITE, 3'd0, 3'd0, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b1, 4'd8, CMD_WRITE, 3'd0, 3'd0, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_RUN,   3'd0, 3'd0, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_WRITE, 3'd7, 3'd7, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_RUN,   3'd0, 3'd0, 1'b0, 1'b1, 3'd7, 3'd7, 1'b1},
        '{1'b1, 4'd2, CMD_WRITE, 3'd0, 3'd0, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_RUN,   3'd0, 3'd0, 1'b0, 1'b1, 3'd1, 3'd1, 1'b1},
        '{1'b1, 4'd0, CMD_WRITE, 3'd0, 3'd0, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_RUN,   3'd0, 3'd0, 1'b0, 1'b1, 3'd1, 3'd1, 1'b1},
        '{1'b1, 4'd15, CMD_WRITE, 3'd0, 3'd0, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_RUN,   3'd0, 3'd0, 1'b0, 1'b1, 3'd7, 3'd7, 1'b1},
        '{1'b0, 4'd0, CMD_WRITE, 3'd6, 3'd7, 1'b1, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_WRITE, 3'd7, 3'd6, 1'b1, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_RUN,   3'd0, 3'd0, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_WRITE, 3'd6, 3'd7, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0},
        '{1'b0, 4'd0, CMD_WRITE, 3'd7, 3'd6, 1'b0, 1'b0, 3'd0, 3'd0, 1'b0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_cmd = CMD_WRITE;
    logic [2:0]        i_row = 3'd0;
    logic [2:0]        i_col = 3'd0;
    logic              i_wall = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [SIZE_W-1:0] i_cfg_data = '0;
    logic              o_valid;
    logic [2:0]        o_visit_row;
    logic [2:0]        o_visit_col;
    logic              o_reached_goal;
    logic              o_last;

    // bench copy of the block state
    logic [63:0]       wall_bits = '0;
    logic [SIZE_W-1:0] grid_n_reg = SIZE_RESET;
    visit_t            pending_visits [$];
    visit_t            final_word;

    int cycle_count   = 0;
    int mismatches    = 0;
    int words_checked = 0;
    int runs_done     = 0;
    int goals_hit     = 0;
    int cell_writes   = 0;

    grid_maze_depth_first_search_top #(
        .GRID_SIZE(GRID_N)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_wall        (i_wall),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_visit_row   (o_visit_row),
        .o_visit_col   (o_visit_col),
        .o_reached_goal(o_reached_goal),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0d] mismatch: %s", cycle_count, msg);
        end
    endfunction

    // expands one run into its visit words, in walk order
    function automatic void walk_maze();
        int         n;
        int         gr;
        int         depth;
        int         r;
        int         c;
        int         nr;
        int         nc;
        int         cell_idx;
        int         d;
        logic [63:0] seen;
        logic [5:0] trail [64];
        bit         moved;
        bit         done;
        visit_t     run_words [$];
        n = (grid_n_reg < SIZE_MIN) ? SIZE_MIN :
            ((grid_n_reg > GRID_N) ? GRID_N : grid_n_reg);
        gr = n - 1;
        seen = 64'd1;
        trail[0] = 6'd0;
        depth = 1;
        done = 1'b0;
        run_words.push_back(visit_t'(8'd0));
        while (depth > 0 && !done) begin
            r = trail[depth-1][5:3];
            c = trail[depth-1][2:0];
            moved = 1'b0;
            for (d = 0; d < 4 && !moved; d++) begin
                nr = r;
                nc = c;
                case (2'(d))
                    DIR_RIGHT: nc = c + 1;
                    DIR_UP:    nr = r - 1;
                    DIR_LEFT:  nc = c - 1;
                    default:   nr = r + 1;
                endcase
                if (nr >= 0 && nc >= 0 && nr < n && nc < n) begin
                    cell_idx = nr * 8 + nc;
                    if (!wall_bits[cell_idx] && !seen[cell_idx]) begin
                        seen[cell_idx] = 1'b1;
                        if (depth < 64) begin
                            trail[depth] = cell_idx[5:0];
                            depth++;
                        end
                        moved = 1'b1;
                        if (nr == gr && nc == gr) begin
                            run_words.push_back(visit_t'({3'(nr), 3'(nc), 2'b11}));
                            done = 1'b1;
                        end else if (run_words.size() < 64) begin
                            run_words.push_back(visit_t'({3'(nr), 3'(nc), 2'b00}));
                        end
                    end
                end
            end
            if (!moved) depth--;
        end
        // walk ran dry: the last cell entered closes the run
        if (!done) run_words[run_words.size()-1].last = 1'b1;
        final_word = run_words[run_words.size()-1];
        foreach (run_words[k]) pending_visits.push_back(run_words[k]);
    endfunction

    always @(posedge i_clk) begin : check_words
        visit_t got;
        visit_t want;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                got = {o_visit_row, o_visit_col, o_reached_goal, o_last};
                if (pending_visits.size() == 0) begin
                    note_mismatch($sformatf("unexpected word row %0d col %0d goal %b last %b",
                                            got.row, got.col, got.goal, got.last));
                end else begin
                    want = pending_visits.pop_front();
                    words_checked++;
                    if (got.row !== want.row || got.col !== want.col ||
                        got.goal !== want.goal || got.last !== want.last) begin
                        note_mismatch($sformatf(
                            "exp row %0d col %0d goal %b last %b, got row %0d col %0d goal %b last %b",
                            want.row, want.col, want.goal, want.last,
                            got.row, got.col, got.goal, got.last));
                    end
                    if (want.last) runs_done++;
                    if (want.goal) goals_hit++;
                end
            end
            if (i_cfg_we) grid_n_reg = i_cfg_data;
            if (start && busy === 1'b0) begin
                if (i_cmd == CMD_WRITE) begin
                    wall_bits[{i_row, i_col}] = i_wall;
                    cell_writes++;
                end else begin
                    walk_maze();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("grid_maze_depth_first_search_top verification failed");
            $finish;
        end
    end

    // called just after a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic cmd, input logic [2:0] row, input logic [2:0] col,
                             input logic wall);
        start  <= 1'b1;
        i_cmd  <= cmd;
        i_row  <= row;
        i_col  <= col;
        i_wall <= wall;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int pct);
        int g;
        g = 0;
        while (g < 60 && $urandom_range(99) < pct) g++;
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    // hold off until every visit word is back and the walker has gone quiet
    task automatic settle();
        start <= 1'b0;
        while (pending_visits.size() != 0 || busy !== 1'b0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        step_t st;
        int    pct;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (SCRIPT[k]) begin
            st = SCRIPT[k];
            if (st.is_cfg) begin
                write_size(st.size);
            end else begin
                idle_gap(30);
                send_word(st.cmd, st.row, st.col, st.wall);
                if (st.typed && final_word !== {st.fin_row, st.fin_col, st.fin_goal, 1'b1}) begin
                    note_mismatch($sformatf("script row %0d ends at row %0d col %0d goal %b",
                                            k, final_word.row, final_word.col, final_word.goal));
                end
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            pct = IDLE_PCT[ph];
            // mostly legal sizes, now and then any value, which may need clamping
            if ($urandom_range(3) == 0) write_size(SIZE_W'($urandom_range(15)));
            else write_size(SIZE_W'($urandom_range(GRID_N, 2)));
            for (int k = 0; k < PHASE_WORDS; k++) begin
                idle_gap(pct);
                if (k == PHASE_WORDS - 1 || $urandom_range(5) == 0) begin
                    send_word(CMD_RUN, 3'($urandom_range(7)), 3'($urandom_range(7)),
                              1'($urandom_range(1)));
                end else begin
                    send_word(CMD_WRITE, 3'($urandom_range(7)), 3'($urandom_range(7)),
                              $urandom_range(99) < 30);
                end
            end
        end

        settle();
        repeat (20) @(negedge i_clk);
        $display("covered %0d cell writes and %0d runs (%0d reached the far corner)",
                 cell_writes, runs_done, goals_hit);
        $display("checked %0d visit words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0 && pending_visits.size() == 0) begin
            $display("grid_maze_depth_first_search_top verification clean");
        end else begin
            $display("grid_maze_depth_first_search_top verification failed");
        end
        $finish;
    end

endmodule

/* grid_maze_depth_first_search_top.f */
src/gmd_pkg.sv
src/gmd_ram.sv
src/gmd_ctrl.sv
src/gmd_dpath.sv
src/grid_maze_depth_first_search_top.sv
test/grid_maze_depth_first_search_top_tb.sv
